>>> rtl/core/adg_pkg.sv
package adg_pkg;

    localparam int unsigned GRAD_W  = 16;
    localparam int unsigned HIST_W  = 40;
    localparam int unsigned UPD_W   = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 1;
    localparam int unsigned ROOT_W  = HIST_W / 2;
    // learning_rate * |gradient| * 16
    localparam int unsigned NUM_W   = CFG_W + GRAD_W + 4;
    // root + epsilon
    localparam int unsigned DEN_W   = ROOT_W + 1;

    localparam logic [IDX_W-1:0] CFG_LEARNING_RATE = 1'b0;
    localparam logic [IDX_W-1:0] CFG_EPSILON       = 1'b1;

    localparam logic [CFG_W-1:0] LR_RESET  = 16'd41;
    localparam logic [CFG_W-1:0] EPS_RESET = 16'd1;

endpackage

>>> rtl/core/adg_isqrt_pipe.sv
// Floor square root, one result bit per pipeline stage.
module adg_isqrt_pipe #(
    parameter int unsigned IN_W   = 40,
    parameter int unsigned SIDE_W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [IN_W-1:0]       i_value,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [IN_W/2-1:0]     o_root,
    output logic [SIDE_W-1:0]     o_side
);

    localparam int unsigned N  = IN_W / 2;
    localparam int unsigned RW = N + 3;

    logic [RW-1:0]     s_rem  [0:N];
    logic [N-1:0]      s_res  [0:N];
    logic [IN_W-1:0]   s_val  [0:N];
    logic [SIDE_W-1:0] s_side [0:N];
    logic              s_vld  [0:N];

    logic [RW-1:0]     r_rem  [0:N-1];
    logic [N-1:0]      r_res  [0:N-1];
    logic [IN_W-1:0]   r_val  [0:N-1];
    logic [SIDE_W-1:0] r_side [0:N-1];
    logic              r_vld  [0:N-1];

    assign s_rem[0]  = '0;
    assign s_res[0]  = '0;
    assign s_val[0]  = i_value;
    assign s_side[0] = i_side;
    assign s_vld[0]  = i_valid;

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic          ge;

        // bring down the next two radicand bits and try a 1 digit
        assign rem_sh = {s_rem[i][RW-3:0], s_val[i][IN_W-1 -: 2]};
        assign trial  = {1'b0, s_res[i], 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= s_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i]  <= ge ? (rem_sh - trial) : rem_sh;
                r_res[i]  <= {s_res[i][N-2:0], ge};
                r_val[i]  <= {s_val[i][IN_W-3:0], 2'b00};
                r_side[i] <= s_side[i];
            end
        end

        assign s_rem[i+1]  = r_rem[i];
        assign s_res[i+1]  = r_res[i];
        assign s_val[i+1]  = r_val[i];
        assign s_side[i+1] = r_side[i];
        assign s_vld[i+1]  = r_vld[i];
    end

    assign o_valid = s_vld[N];
    assign o_root  = s_res[N];
    assign o_side  = s_side[N];

endmodule

>>> rtl/core/adg_div_pipe.sv
// Restoring unsigned divider, one quotient bit per pipeline stage.
module adg_div_pipe #(
    parameter int unsigned NUM_W  = 36,
    parameter int unsigned DEN_W  = 21,
    parameter int unsigned SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quot,
    output logic [SIDE_W-1:0] o_side
);

    logic [DEN_W-1:0]  s_rem  [0:NUM_W];
    logic [NUM_W-1:0]  s_quot [0:NUM_W];
    logic [NUM_W-1:0]  s_num  [0:NUM_W];
    logic [DEN_W-1:0]  s_den  [0:NUM_W];
    logic [SIDE_W-1:0] s_side [0:NUM_W];
    logic              s_vld  [0:NUM_W];

    logic [DEN_W-1:0]  r_rem  [0:NUM_W-1];
    logic [NUM_W-1:0]  r_quot [0:NUM_W-1];
    logic [NUM_W-1:0]  r_num  [0:NUM_W-1];
    logic [DEN_W-1:0]  r_den  [0:NUM_W-1];
    logic [SIDE_W-1:0] r_side [0:NUM_W-1];
    logic              r_vld  [0:NUM_W-1];

    assign s_rem[0]  = '0;
    assign s_quot[0] = '0;
    assign s_num[0]  = i_num;
    assign s_den[0]  = i_den;
    assign s_side[0] = i_side;
    assign s_vld[0]  = i_valid;

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        logic [DEN_W:0] rem_sh;
        logic [DEN_W:0] diff;
        logic           ge;

        // shift in the next dividend bit, subtract when it fits
        assign rem_sh = {s_rem[i], s_num[i][NUM_W-1]};
        assign ge     = rem_sh >= {1'b0, s_den[i]};
        assign diff   = rem_sh - {1'b0, s_den[i]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= s_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i]  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                r_quot[i] <= {s_quot[i][NUM_W-2:0], ge};
                r_num[i]  <= {s_num[i][NUM_W-2:0], 1'b0};
                r_den[i]  <= s_den[i];
                r_side[i] <= s_side[i];
            end
        end

        assign s_rem[i+1]  = r_rem[i];
        assign s_quot[i+1] = r_quot[i];
        assign s_num[i+1]  = r_num[i];
        assign s_den[i+1]  = r_den[i];
        assign s_side[i+1] = r_side[i];
        assign s_vld[i+1]  = r_vld[i];
    end

    assign o_valid = s_vld[NUM_W];
    assign o_quot  = s_quot[NUM_W];
    assign o_side  = s_side[NUM_W];

endmodule

>>> rtl/core/adagrad_update_element.sv
// Per-element AdaGrad update.
// Input channel (i_valid / o_ready) carries one gradient (signed Q3.12) and
// its prior squared-gradient history (unsigned Q16.24). The output channel
// (o_valid / i_ready) returns the saturated new history and the update
// step lr * g / (sqrt(history) + eps) in signed Q15.16.
// Configuration: i_cfg_we writes i_cfg_data to learning_rate (index 0) or
// epsilon (index 1) register at the clock edge; other indexes are ignored. An
// epsilon of zero acts as one LSB.
// Throughput: one request per cycle while the receiver does not stall. The
// pipeline has 60 register stages: the 20-stage square root
// and the 36-stage divider, one bit per stage, plus product, sum,
// denominator and output stages.
// Reset (synchronous, active low) empties the pipeline and restores
// learning_rate = 41 and epsilon = 1.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_ready drops; nothing is lost or repeated. A new request is taken
// only in cycles where the pipeline advances.
module adagrad_update_element (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [adg_pkg::GRAD_W-1:0] i_gradient,
    input  logic [adg_pkg::HIST_W-1:0]       i_prior_history,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [adg_pkg::HIST_W-1:0]       o_new_history,
    output logic signed [adg_pkg::UPD_W-1:0] o_update_step,
    input  logic                             i_cfg_we,
    input  logic [adg_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [adg_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int unsigned GW  = adg_pkg::GRAD_W;
    localparam int unsigned HW  = adg_pkg::HIST_W;
    localparam int unsigned UW  = adg_pkg::UPD_W;
    localparam int unsigned CW  = adg_pkg::CFG_W;
    localparam int unsigned RW  = adg_pkg::ROOT_W;
    localparam int unsigned NW  = adg_pkg::NUM_W;
    localparam int unsigned DW  = adg_pkg::DEN_W;
    localparam int unsigned SQ_SIDE = 1 + NW + HW;
    localparam int unsigned DV_SIDE = 1 + HW;

    logic [CW-1:0] r_lr;
    logic [CW-1:0] r_eps;
    logic          en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr  <= adg_pkg::LR_RESET;
            r_eps <= adg_pkg::EPS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                adg_pkg::CFG_LEARNING_RATE: r_lr  <= i_cfg_data;
                adg_pkg::CFG_EPSILON:       r_eps <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic r_out_vld;
    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;

    // stage 0: magnitude, square and numerator products
    logic          neg;
    logic [GW-1:0] gmag;
    assign neg  = i_gradient[GW-1];
    assign gmag = neg ? (~i_gradient + 1'b1) : i_gradient;

    logic            r0_vld;
    logic            r0_neg;
    logic [HW-1:0]   r0_prior;
    logic [2*GW-1:0] r0_sq;
    logic [CW+GW-1:0] r0_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_neg   <= neg;
            r0_prior <= i_prior_history;
            r0_sq    <= gmag * gmag;
            r0_prod  <= r_lr * gmag;
        end
    end

    // stage 1: history sum with saturation
    logic [HW:0] hsum;
    assign hsum = {1'b0, r0_prior} + {{(HW+1-2*GW){1'b0}}, r0_sq};

    logic          r1_vld;
    logic          r1_neg;
    logic [HW-1:0] r1_hist;
    logic [NW-1:0] r1_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_neg  <= r0_neg;
            r1_hist <= hsum[HW] ? {HW{1'b1}} : hsum[HW-1:0];
            r1_num  <= {r0_prod, 4'b0000};
        end
    end

    // square root of the new history
    logic               sq_vld;
    logic [RW-1:0]      sq_root;
    logic [SQ_SIDE-1:0] sq_side;

    adg_isqrt_pipe #(
        .IN_W   (HW),
        .SIDE_W (SQ_SIDE)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r1_vld),
        .i_value (r1_hist),
        .i_side  ({r1_neg, r1_num, r1_hist}),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // denominator: root plus effective epsilon
    logic [CW-1:0] eps_eff;
    assign eps_eff = (r_eps == '0) ? CW'(1) : r_eps;

    logic          r2_vld;
    logic          r2_neg;
    logic [HW-1:0] r2_hist;
    logic [NW-1:0] r2_num;
    logic [DW-1:0] r2_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_neg  <= sq_side[SQ_SIDE-1];
            r2_num  <= sq_side[HW +: NW];
            r2_hist <= sq_side[HW-1:0];
            r2_den  <= {1'b0, sq_root} + {{(DW-CW){1'b0}}, eps_eff};
        end
    end

    // quotient
    logic               dv_vld;
    logic [NW-1:0]      dv_quot;
    logic [DV_SIDE-1:0] dv_side;

    adg_div_pipe #(
        .NUM_W  (NW),
        .DEN_W  (DW),
        .SIDE_W (DV_SIDE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_vld),
        .i_num   (r2_num),
        .i_den   (r2_den),
        .i_side  ({r2_neg, r2_hist}),
        .o_valid (dv_vld),
        .o_quot  (dv_quot),
        .o_side  (dv_side)
    );

    // sign and saturation into the output register
    localparam logic [NW-1:0] POS_MAX = NW'({1'b0, {(UW-1){1'b1}}});
    localparam logic [NW-1:0] NEG_MAX = NW'({1'b1, {(UW-1){1'b0}}});

    logic          dv_neg;
    logic [UW-1:0] mag;
    logic [UW-1:0] upd;
    assign dv_neg = dv_side[DV_SIDE-1];

    always_comb begin
        if (dv_neg) begin
            mag = (dv_quot > NEG_MAX) ? NEG_MAX[UW-1:0] : dv_quot[UW-1:0];
            upd = ~mag + 1'b1;
        end else begin
            mag = (dv_quot > POS_MAX) ? POS_MAX[UW-1:0] : dv_quot[UW-1:0];
            upd = mag;
        end
    end

    logic [HW-1:0] r_out_hist;
    logic [UW-1:0] r_out_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_hist <= dv_side[HW-1:0];
            r_out_upd  <= upd;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_new_history = r_out_hist;
    assign o_update_step = r_out_upd;

endmodule
